### hdl/ldsc_pkg.sv
// shared types and constants for the led digit shadow command generator
package ldsc_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_CODE  = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_RAW   = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // new digit value and render mode for one update
    typedef struct packed {
        logic [7:0] value;
        logic       decoded;
    } map_result_t;

    localparam logic [7:0] DECODE_ADDR = 8'h09;
    localparam logic [7:0] BLANK       = 8'h0F;
    localparam logic [7:0] CODE_ALL    = 8'hFF;
    localparam logic [7:0] CODE_CLAMP  = 8'h7F;
    localparam logic [7:0] DOT_BIT     = 8'h80;

    // code-b values for letters the driver decodes
    localparam logic [7:0] CODE_DASH = 8'h0A;
    localparam logic [7:0] CODE_E    = 8'h0B;
    localparam logic [7:0] CODE_H    = 8'h0C;
    localparam logic [7:0] CODE_L    = 8'h0D;
    localparam logic [7:0] CODE_P    = 8'h0E;

    // raw segment patterns for letters outside code-b
    localparam logic [7:0] SEG_A = 8'h77;
    localparam logic [7:0] SEG_B = 8'h1F;
    localparam logic [7:0] SEG_C = 8'h4E;
    localparam logic [7:0] SEG_D = 8'h3D;
    localparam logic [7:0] SEG_F = 8'h47;

endpackage

### hdl/ldsc_value_map.sv
// maps one digit update to its stored value and render mode
module ldsc_value_map (
    input  ldsc_pkg::kind_t       kind,
    input  logic [7:0]            value,
    input  logic [7:0]            char_code,
    input  logic                  dot,
    output ldsc_pkg::map_result_t result
);

    logic [7:0] char_val;
    logic       char_dec;
    logic [7:0] dot_mask;

    assign dot_mask = dot ? ldsc_pkg::DOT_BIT : 8'h00;

    // ascii lookup
    always_comb begin
        char_dec = 1'b1;
        char_val = ldsc_pkg::BLANK;
        if (char_code >= 8'h30 && char_code <= 8'h39) begin
            char_val = char_code - 8'h30;
        end else begin
            case (char_code)
                8'h2D: char_val = ldsc_pkg::CODE_DASH;          // '-'
                8'h45, 8'h65: char_val = ldsc_pkg::CODE_E;
                8'h48, 8'h68: char_val = ldsc_pkg::CODE_H;
                8'h4C, 8'h6C: char_val = ldsc_pkg::CODE_L;
                8'h50, 8'h70: char_val = ldsc_pkg::CODE_P;
                8'h41, 8'h61: begin
                    char_val = ldsc_pkg::SEG_A;
                    char_dec = 1'b0;
                end
                8'h42, 8'h62: begin
                    char_val = ldsc_pkg::SEG_B;
                    char_dec = 1'b0;
                end
                8'h43, 8'h63: begin
                    char_val = ldsc_pkg::SEG_C;
                    char_dec = 1'b0;
                end
                8'h44, 8'h64: begin
                    char_val = ldsc_pkg::SEG_D;
                    char_dec = 1'b0;
                end
                8'h46, 8'h66: begin
                    char_val = ldsc_pkg::SEG_F;
                    char_dec = 1'b0;
                end
                default: char_val = ldsc_pkg::BLANK;
            endcase
        end
    end

    always_comb begin
        case (kind)
            ldsc_pkg::KIND_CODE: begin
                result.value   = ((value == ldsc_pkg::CODE_ALL) ? ldsc_pkg::CODE_CLAMP : value)
                                 | dot_mask;
                result.decoded = 1'b1;
            end
            ldsc_pkg::KIND_CHAR: begin
                result.value   = char_val | dot_mask;
                result.decoded = char_dec;
            end
            ldsc_pkg::KIND_RAW: begin
                result.value   = value;
                result.decoded = 1'b0;
            end
            default: begin
                result.value   = ldsc_pkg::BLANK;
                result.decoded = 1'b1;
            end
        endcase
    end

endmodule

### hdl/led_digit_shadow_command_gen_unit.sv
// top level of the led digit shadow command generator
//
// keeps a shadow of up to MAX_DIGITS seven-segment digits (value byte, render
// mode) plus the driver's decode-mode byte, and turns each digit update into
// the 16-bit driver command words that bring the display up to date
// input channel: s_tvalid / s_tready, s_tuser = kind, s_tdata = digit fields
// output channel: m_tvalid / m_tready, m_tdata = command word, m_tlast marks
// the final word caused by one input transaction
// cfg_we / cfg_wdata write the digit count; write it only while idle
// timing: one transaction at a time; s_tready is low from acceptance until
// all words are loaded into the output register
//   first command word: loaded by an emit state after the evaluate state
//   update: accept, evaluate, then one emit state per word (0, 1 or 2 words)
//   clear: accept, evaluate, then 2 * n words
// the single digit-address subtractor (n - 1 - position) is shared between
// updates and the clear sweep, which walks the digits from position 0 upward
// a stalled receiver holds the output register; the sequencer simply waits
// reset: shadow blank and decoded, decode byte all ones, digit count 8
module led_digit_shadow_command_gen_unit #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: digit count
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    input  logic [23:0] s_tdata,   // digit_index[2:0], value[10:3], char_code[18:11], dot[19]
    // command word transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // command_word[15:0]
    output logic        m_tlast
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT_DEC,
        ST_EMIT_DIG,
        ST_CLR_DEC,
        ST_CLR_DIG
    } state_t;

    state_t state_reg, state_next;

    // latched item
    ldsc_pkg::kind_t kind_reg, kind_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] value_reg, value_next;
    logic [7:0] char_reg, char_next;
    logic       dot_reg, dot_next;

    logic [3:0] num_digits_reg, num_digits_next;

    // shadow
    logic [7:0] digit_val_reg [MAX_DIGITS];
    logic [7:0] digit_val_next [MAX_DIGITS];
    logic       render_dec_reg [MAX_DIGITS];
    logic       render_dec_next [MAX_DIGITS];
    logic [7:0] decode_bits_reg, decode_bits_next;
    logic [3:0] clear_pos_reg, clear_pos_next;

    // pending digit word
    logic [3:0] dig_addr_reg, dig_addr_next;
    logic [7:0] word_val_reg, word_val_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    ldsc_pkg::map_result_t map_res;

    logic [3:0] n_eff;
    logic [3:0] pos_sel;
    logic [3:0] dig_addr_calc;
    logic [7:0] dbit;
    logic       can_load;
    logic       in_range;
    logic [7:0] cur_val;
    logic       cur_dec;
    logic       mode_changed;
    logic       value_changed;
    logic       clear_done;

    ldsc_value_map u_map (
        .kind      (kind_reg),
        .value     (value_reg),
        .char_code (char_reg),
        .dot       (dot_reg),
        .result    (map_res)
    );

    // effective count, saturated at the parameter
    assign n_eff = (num_digits_reg > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : num_digits_reg;

    // shared address unit: driver digit number counted from the right, from zero
    assign pos_sel       = (state_reg == ST_EVAL) ? {1'b0, idx_reg} : clear_pos_reg;
    assign dig_addr_calc = n_eff - 4'd1 - pos_sel;
    assign dbit          = 8'h01 << dig_addr_calc[2:0];

    assign can_load   = !out_valid_reg || m_tready;
    assign in_range   = {1'b0, idx_reg} < n_eff;
    assign cur_val    = digit_val_reg[idx_reg[IDX_W-1:0]];
    assign cur_dec    = render_dec_reg[idx_reg[IDX_W-1:0]];
    assign mode_changed  = cur_dec != map_res.decoded;
    assign value_changed = cur_val != map_res.value;
    assign clear_done = clear_pos_reg == (n_eff - 4'd1);

    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        value_next       = value_reg;
        char_next        = char_reg;
        dot_next         = dot_reg;
        num_digits_next  = num_digits_reg;
        digit_val_next   = digit_val_reg;
        render_dec_next  = render_dec_reg;
        decode_bits_next = decode_bits_reg;
        clear_pos_next   = clear_pos_reg;
        dig_addr_next    = dig_addr_reg;
        word_val_next    = word_val_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        if (cfg_we) begin
            num_digits_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = ldsc_pkg::kind_t'(s_tuser);
                    idx_next   = s_tdata[2:0];
                    value_next = s_tdata[10:3];
                    char_next  = s_tdata[18:11];
                    dot_next   = s_tdata[19];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (kind_reg == ldsc_pkg::KIND_CLEAR) begin
                    clear_pos_next = 4'd0;
                    state_next     = (n_eff == 4'd0) ? ST_IDLE : ST_CLR_DEC;
                end else if (!in_range) begin
                    state_next = ST_IDLE;
                end else begin
                    digit_val_next[idx_reg[IDX_W-1:0]]  = map_res.value;
                    render_dec_next[idx_reg[IDX_W-1:0]] = map_res.decoded;
                    dig_addr_next = dig_addr_calc;
                    word_val_next = map_res.value;
                    if (mode_changed) begin
                        decode_bits_next = map_res.decoded ? (decode_bits_reg | dbit)
                                                           : (decode_bits_reg & ~dbit);
                        state_next = ST_EMIT_DEC;
                    end else if (value_changed) begin
                        state_next = ST_EMIT_DIG;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_DEC: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ldsc_pkg::DECODE_ADDR, decode_bits_reg};
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT_DIG;
                end
            end
            ST_EMIT_DIG: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, dig_addr_reg + 4'd1, word_val_reg};
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLR_DEC: begin
                if (can_load) begin
                    decode_bits_next = decode_bits_reg | dbit;
                    out_valid_next   = 1'b1;
                    out_data_next    = {ldsc_pkg::DECODE_ADDR, decode_bits_reg | dbit};
                    out_last_next    = 1'b0;
                    dig_addr_next    = dig_addr_calc;
                    digit_val_next[clear_pos_reg[IDX_W-1:0]]  = ldsc_pkg::BLANK;
                    render_dec_next[clear_pos_reg[IDX_W-1:0]] = 1'b1;
                    state_next       = ST_CLR_DIG;
                end
            end
            ST_CLR_DIG: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, dig_addr_reg + 4'd1, ldsc_pkg::BLANK};
                    out_last_next  = clear_done;
                    if (clear_done) begin
                        clear_pos_next = 4'd0;
                        state_next     = ST_IDLE;
                    end else begin
                        clear_pos_next = clear_pos_reg + 4'd1;
                        state_next     = ST_CLR_DEC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            num_digits_reg  <= 4'd8;
            decode_bits_reg <= 8'hFF;
            clear_pos_reg   <= 4'd0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                digit_val_reg[i]  <= ldsc_pkg::BLANK;
                render_dec_reg[i] <= 1'b1;
            end
        end else begin
            state_reg       <= state_next;
            num_digits_reg  <= num_digits_next;
            decode_bits_reg <= decode_bits_next;
            clear_pos_reg   <= clear_pos_next;
            out_valid_reg   <= out_valid_next;
            digit_val_reg   <= digit_val_next;
            render_dec_reg  <= render_dec_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        value_reg    <= value_next;
        char_reg     <= char_next;
        dot_reg      <= dot_next;
        dig_addr_reg <= dig_addr_next;
        word_val_reg <= word_val_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // one transaction at a time: no second accept right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous item still in progress");

    // a decode-mode word is never the final word of an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:8] == ldsc_pkg::DECODE_ADDR) |-> !m_tlast)
        else $error("decode-mode word marked last");

    // every command word targets the decode register or a digit address from 1 to MAX_DIGITS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:8] == ldsc_pkg::DECODE_ADDR ||
                      (m_tdata[15:8] != 8'd0 && m_tdata[15:8] <= 8'(MAX_DIGITS))))
        else $error("command word with bad register address");

    // the clear sweep never runs past the digit count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR_DEC || state_reg == ST_CLR_DIG) |-> (clear_pos_reg < n_eff))
        else $error("clear position beyond digit count");

endmodule

### test/led_digit_shadow_command_gen_unit_tb.sv
// self-checking testbench for the led digit shadow command generator
`timescale 1ns / 1ps

module led_digit_shadow_command_gen_unit_tb;

    localparam int DIGIT_LIMIT    = 8;
    // cycles allowed for an update that emits nothing to finish its evaluate step
    localparam int SETTLE_CYCLES  = 20;
    // cycles with no transaction on any side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 40;

    // one digit update as it travels on the input channel
    typedef struct {
        ldsc_pkg::kind_t kind;
        logic [2:0]      idx;
        logic [7:0]      value;
        logic [7:0]      ch;
        logic            dot;
    } digit_item_t;

    // one predicted command word with its end-of-item marker
    typedef struct {
        logic [15:0] word;
        logic        last;
    } command_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = 2'd0;   // kind
    logic [23:0] s_tdata   = 24'd0;  // digit_index[2:0], value[10:3], char_code[18:11], dot[19]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // command_word[15:0]
    logic        m_tlast;

    // updates waiting to be sent, head is the one on the bus
    digit_item_t update_q[$];
    // command words the shadow model says must come out, oldest first
    command_t    cmd_word_q[$];

    // shadow model of the display driver state
    logic [7:0]  shadow_val[DIGIT_LIMIT];
    logic        shadow_dec[DIGIT_LIMIT];
    logic [7:0]  shadow_decode;
    logic [3:0]  digit_count;

    digit_item_t last_item;
    int          fail_count  = 0;
    int          idle_cycles = 0;

    // sender burst shaping
    int          burst_left = 0;
    int          gap_left   = 0;

    // receiver stall pattern
    int          rx_mode      = 0;
    int          rx_mode_left = 0;
    int          rx_stall     = 0;

    string       char_set = "0123456789-EeHhLlPpAaBbCcDdFf";

    led_digit_shadow_command_gen_unit #(
        .MAX_DIGITS(DIGIT_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // works out the command words one accepted update causes and advances the shadow
    function automatic void predict_commands(input digit_item_t it);
        int          n;
        int          pos;
        logic [7:0]  nv;
        logic        dec;
        logic        value_chg;
        logic        mode_chg;
        logic [15:0] words[$];
        command_t    cw;
        n = (digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(digit_count);
        if (it.kind == ldsc_pkg::KIND_CLEAR) begin
            // left to right, decode word then blank digit word for each position
            for (int i = 0; i < n; i++) begin
                pos = n - 1 - i;
                shadow_val[i] = ldsc_pkg::BLANK;
                shadow_dec[i] = 1'b1;
                shadow_decode[pos] = 1'b1;
                words.push_back({ldsc_pkg::DECODE_ADDR, shadow_decode});
                words.push_back({8'(pos + 1), ldsc_pkg::BLANK});
            end
        end else if (int'(it.idx) < n) begin
            dec = 1'b1;
            case (it.kind)
                ldsc_pkg::KIND_CODE: begin
                    nv = (it.value == ldsc_pkg::CODE_ALL) ? ldsc_pkg::CODE_CLAMP : it.value;
                    if (it.dot) nv = nv | ldsc_pkg::DOT_BIT;
                end
                ldsc_pkg::KIND_CHAR: begin
                    if (it.ch >= "0" && it.ch <= "9") begin
                        nv = it.ch - "0";
                    end else begin
                        case (it.ch)
                            "-":      nv = ldsc_pkg::CODE_DASH;
                            "E", "e": nv = ldsc_pkg::CODE_E;
                            "H", "h": nv = ldsc_pkg::CODE_H;
                            "L", "l": nv = ldsc_pkg::CODE_L;
                            "P", "p": nv = ldsc_pkg::CODE_P;
                            "A", "a": begin nv = ldsc_pkg::SEG_A; dec = 1'b0; end
                            "B", "b": begin nv = ldsc_pkg::SEG_B; dec = 1'b0; end
                            "C", "c": begin nv = ldsc_pkg::SEG_C; dec = 1'b0; end
                            "D", "d": begin nv = ldsc_pkg::SEG_D; dec = 1'b0; end
                            "F", "f": begin nv = ldsc_pkg::SEG_F; dec = 1'b0; end
                            default:  nv = ldsc_pkg::BLANK;
                        endcase
                    end
                    if (it.dot) nv = nv | ldsc_pkg::DOT_BIT;
                end
                default: begin
                    // raw segments, dot has no effect
                    nv  = it.value;
                    dec = 1'b0;
                end
            endcase
            pos       = n - 1 - int'(it.idx);
            value_chg = shadow_val[it.idx] != nv;
            mode_chg  = shadow_dec[it.idx] != dec;
            shadow_val[it.idx] = nv;
            shadow_dec[it.idx] = dec;
            if (mode_chg) begin
                shadow_decode[pos] = dec;
                words.push_back({ldsc_pkg::DECODE_ADDR, shadow_decode});
                value_chg = 1'b1;
            end
            if (value_chg) words.push_back({8'(pos + 1), nv});
        end
        foreach (words[k]) begin
            cw.word = words[k];
            cw.last = (k == words.size() - 1);
            cmd_word_q.push_back(cw);
        end
    endfunction

    function automatic digit_item_t make_item(input ldsc_pkg::kind_t kind,
                                              input logic [2:0] idx,
                                              input logic [7:0] value, input logic [7:0] ch,
                                              input logic dot);
        digit_item_t it;
        it.kind  = kind;
        it.idx   = idx;
        it.value = value;
        it.ch    = ch;
        it.dot   = dot;
        return it;
    endfunction

    // random update, mostly inside the attached digits, with repeats to hit no-change
    function automatic digit_item_t random_update();
        digit_item_t it;
        int          r;
        int          n;
        n = (digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(digit_count);
        r = $urandom_range(0, 99);
        it.kind  = (r < 6)  ? ldsc_pkg::KIND_CLEAR :
                   (r < 40) ? ldsc_pkg::KIND_CODE  :
                   (r < 70) ? ldsc_pkg::KIND_CHAR  : ldsc_pkg::KIND_RAW;
        it.idx   = ($urandom_range(0, 4) != 0 && n > 0) ? 3'($urandom_range(0, n - 1))
                                                        : 3'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        it.value = (r == 0) ? ldsc_pkg::CODE_ALL :
                   (r == 1) ? ldsc_pkg::BLANK    : 8'($urandom_range(0, 255));
        it.ch    = ($urandom_range(0, 9) < 7) ? 8'(char_set[$urandom_range(0, char_set.len() - 1)])
                                              : 8'($urandom_range(0, 255));
        it.dot   = 1'($urandom_range(0, 1));
        // resend the previous update now and then, possibly with the same kind and digit but new fields
        r = $urandom_range(0, 99);
        if (r < 10) it = last_item;
        else if (r < 15) begin
            it.kind = last_item.kind;
            it.idx  = last_item.idx;
        end
        last_item = it;
        return it;
    endfunction

    // block until every pending update is accepted and every command word checked
    task automatic wait_idle();
        while (update_q.size() != 0 || cmd_word_q.size() != 0) @(negedge aclk);
        // an update that emits nothing may still be in its evaluate step
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_digit_count(input logic [3:0] count);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        digit_count = count;
    endtask

    task automatic run_phase(input logic [3:0] count, input int n_items);
        int left;
        int chunk;
        wait_idle();
        write_digit_count(count);
        left = n_items;
        while (left > 0) begin
            chunk = $urandom_range(4, 24);
            if (chunk > left) chunk = left;
            @(negedge aclk);
            repeat (chunk) update_q.push_back(random_update());
            left -= chunk;
            // sometimes hold the sender off until the output side has fully drained
            if ($urandom_range(0, 3) == 0) wait_idle();
            else while (update_q.size() != 0) @(negedge aclk);
        end
    endtask

    // driver: presents the head of the update queue in bursts with random gaps
    always @(posedge aclk) begin : drive_updates
        logic        nxt_valid;
        digit_item_t head;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                // transaction accepted: predict its command words now
                predict_commands(update_q.pop_front());
                nxt_valid = 1'b0;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left  <= gap_left - 1;
                    nxt_valid = 1'b0;
                end else if (update_q.size() > 0) begin
                    head      = update_q[0];
                    nxt_valid = 1'b1;
                    s_tuser   <= head.kind;
                    s_tdata   <= {4'd0, head.dot, head.ch, head.value, head.idx};
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else if ($urandom_range(0, 4) == 0) begin
                        // long stretch without gaps
                        burst_left <= $urandom_range(30, 60);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25)
                                                                  : $urandom_range(0, 4);
                    end
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // monitor: checks each command word transaction and drives the receiver stalls
    always @(posedge aclk) begin : check_commands
        command_t want;
        logic     ready_nxt;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (cmd_word_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected command word %h last %b at %0t",
                                 m_tdata, m_tlast, $realtime);
                end else begin
                    want = cmd_word_q.pop_front();
                    if (m_tdata !== want.word || m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"command word mismatch: expected %h last %b, ",
                                      "got %h last %b at %0t"},
                                     want.word, want.last, m_tdata, m_tlast, $realtime);
                    end
                end
            end
            // receiver mode: always ready, coin toss, or long stall runs
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: ready_nxt = 1'b1;
                1: ready_nxt = 1'($urandom_range(0, 1));
                default: begin
                    if (rx_stall == 0) begin
                        ready_nxt = 1'b1;
                        rx_stall  = $urandom_range(1, 12);
                    end else begin
                        ready_nxt = 1'b0;
                        rx_stall--;
                    end
                end
            endcase
            m_tready <= ready_nxt;
        end
    end

    // watchdog: a long stretch with no transaction anywhere means the block is stuck
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL led_digit_shadow_command_gen_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < DIGIT_LIMIT; i++) begin
            shadow_val[i] = ldsc_pkg::BLANK;
            shadow_dec[i] = 1'b1;
        end
        shadow_decode = 8'hFF;
        digit_count   = 4'd8;
        last_item     = make_item(ldsc_pkg::KIND_CODE, 3'd0, 8'd0, 8'd0, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed updates with the reset digit count
        update_q.push_back(make_item(ldsc_pkg::KIND_CODE,  3'd0, 8'h00, 8'h00, 1'b0));
        // all-ones clamp plus dot
        update_q.push_back(make_item(ldsc_pkg::KIND_CODE,  3'd7, 8'hFF, 8'h00, 1'b1));
        // unchanged, no words
        update_q.push_back(make_item(ldsc_pkg::KIND_CODE,  3'd7, 8'hFF, 8'hFF, 1'b1));
        // switch to raw
        update_q.push_back(make_item(ldsc_pkg::KIND_RAW,   3'd3, 8'hA5, 8'h00, 1'b0));
        // dot ignored
        update_q.push_back(make_item(ldsc_pkg::KIND_RAW,   3'd3, 8'h5A, 8'h00, 1'b1));
        // back to decoded
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd3, 8'h00, "7",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd0, 8'h00, "0",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd1, 8'h00, "9",   1'b1));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd1, 8'h00, "-",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd2, 8'h00, "e",   1'b1));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd4, 8'h00, "H",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd5, 8'h00, "l",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd6, 8'h00, "P",   1'b1));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd0, 8'h00, "a",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd1, 8'h00, "B",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd2, 8'h00, "c",   1'b1));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd4, 8'h00, "D",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd5, 8'h00, "f",   1'b1));
        // characters without a mapping render blank
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd6, 8'h00, "#",   1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd7, 8'h00, 8'h80, 1'b1));
        update_q.push_back(make_item(ldsc_pkg::KIND_CHAR,  3'd0, 8'hFF, 8'hFF, 1'b0));
        update_q.push_back(make_item(ldsc_pkg::KIND_CLEAR, 3'd5, 8'h33, 8'h44, 1'b1));

        // random phases across digit counts: small, single, none, saturated, full
        run_phase(4'd3,  PHASE_ITEMS);
        run_phase(4'd1,  PHASE_ITEMS);
        run_phase(4'd0,  PHASE_ITEMS);
        run_phase(4'd15, PHASE_ITEMS);
        run_phase(4'd8,  PHASE_ITEMS);
        run_phase(4'd5,  PHASE_ITEMS);
        run_phase(4'd9,  PHASE_ITEMS);
        run_phase(4'd2,  PHASE_ITEMS);
        run_phase(4'd7,  PHASE_ITEMS);
        run_phase(4'd8,  PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS led_digit_shadow_command_gen_unit");
        end else begin
            $display("FAIL led_digit_shadow_command_gen_unit");
        end
        $finish;
    end

endmodule
